// ===== src/bfct_pkg.sv =====
// Shared constants and types for the box frustum corner test unit.
`default_nettype none

package bfct_pkg;

    // Chunk edge in world units, and the same edge in Q16.16.
    localparam int CHUNK_EDGE = 32;
    localparam longint EDGE_Q = longint'(CHUNK_EDGE) * 65536;

    // Fraction bits of Q16.16; the homogeneous w of every corner is one, 1 << FRAC_BITS.
    localparam int FRAC_BITS = 16;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 64;
    localparam int NUM_CFG = 8;
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    localparam int NUM_ROWS = 4;
    localparam int NUM_CORNERS = 8;
    localparam int PROD_W = 2 * COORD_W;

    // Clip sums stay well below 2^68 for any 32-bit inputs and edge <= 1024.
    localparam int ACC_W = 72;

    localparam int IN_W  = 3 * COORD_W;
    localparam int OUT_W = 8;

    // Clip component rows.
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [CFG_W-1:0] t_cfg;

    // Identity matrix after reset.
    localparam t_cfg CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

`default_nettype wire

// ===== src/box_frustum_corner_test_unit.sv =====
// Top level: pipelined clip-space corner test of a cubic chunk against the view volume.
//
//  Channel     Direction  Transfer when                    Payload
//  s_axis      in         i_s_axis_tvalid & o_s_axis_tready  origin x, y, z (Q16.16)
//  m_axis      out        o_m_axis_tvalid & i_m_axis_tready  visible flag
//  cfg         in         i_cfg_we                           clip matrix register write
//
// One origin per cycle enters unless a stalled output has filled the pipe. Five register
// stages: multiply, pair add, row sum, corner offset add, compare and reduce.
// Synchronous active-low reset empties the pipeline and reloads the identity matrix.
// Each stage holds while the stage after it is full and stalled, so bubbles close up
// and input is still taken while a finished verdict waits at the output.
`default_nettype none

module box_frustum_corner_test_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input stream: origin_x [31:0], origin_y [63:32], origin_z [95:64]
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [bfct_pkg::IN_W-1:0]   i_s_axis_tdata,
    // Output stream: visible [0], zero fill [7:1]
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [bfct_pkg::OUT_W-1:0]       o_m_axis_tdata,
    // Configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic [bfct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bfct_pkg::CFG_W-1:0]  i_cfg_wdata
);

    // Matrix registers
    bfct_pkg::t_cfg r_cfg [bfct_pkg::NUM_CFG];

    // Coefficients, split out of the packed registers
    bfct_pkg::t_coord coef [bfct_pkg::NUM_ROWS][4];

    // Per-row edge contributions and per-corner offsets (quasi-static, from config)
    bfct_pkg::t_acc delta [bfct_pkg::NUM_ROWS][3];
    bfct_pkg::t_acc n_off [bfct_pkg::NUM_ROWS][bfct_pkg::NUM_CORNERS];
    bfct_pkg::t_acc r_off [bfct_pkg::NUM_ROWS][bfct_pkg::NUM_CORNERS];

    // Stage valid bits and load enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // Stage 1: products
    bfct_pkg::t_prod r_prod [bfct_pkg::NUM_ROWS][3];
    bfct_pkg::t_acc  r_trans [bfct_pkg::NUM_ROWS];
    // Stage 2: pair sums
    bfct_pkg::t_acc  r_pa [bfct_pkg::NUM_ROWS];
    bfct_pkg::t_acc  r_pb [bfct_pkg::NUM_ROWS];
    // Stage 3: clip components of the minimum corner
    bfct_pkg::t_acc  r_base [bfct_pkg::NUM_ROWS];
    // Stage 4: clip components of all corners
    bfct_pkg::t_acc  r_clip [bfct_pkg::NUM_CORNERS][bfct_pkg::NUM_ROWS];
    // Stage 5: verdict
    logic            r_vis;

    bfct_pkg::t_coord org [3];
    logic [bfct_pkg::NUM_CORNERS-1:0] corner_in;
    logic [bfct_pkg::NUM_CORNERS-1:0] w_pos;

    // Unpack coefficients: row r uses registers 2r (columns 0,1) and 2r+1 (columns 2,3)
    always_comb begin
        for (int r = 0; r < bfct_pkg::NUM_ROWS; r++) begin
            coef[r][0] = bfct_pkg::t_coord'(r_cfg[2*r][31:0]);
            coef[r][1] = bfct_pkg::t_coord'(r_cfg[2*r][63:32]);
            coef[r][2] = bfct_pkg::t_coord'(r_cfg[2*r+1][31:0]);
            coef[r][3] = bfct_pkg::t_coord'(r_cfg[2*r+1][63:32]);
        end
    end

    // Edge step along each axis is a constant multiple of the column coefficient
    always_comb begin
        for (int r = 0; r < bfct_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < 3; c++) begin
                delta[r][c] = bfct_pkg::t_acc'(coef[r][c])
                            * bfct_pkg::t_acc'(bfct_pkg::EDGE_Q);
            end
            // Corner bit 2 steps x, bit 1 steps y, bit 0 steps z
            for (int k = 0; k < bfct_pkg::NUM_CORNERS; k++) begin
                n_off[r][k] = (k[2] ? delta[r][0] : '0)
                            + (k[1] ? delta[r][1] : '0)
                            + (k[0] ? delta[r][2] : '0);
            end
        end
    end

    // Configuration writes; the registered offsets follow in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bfct_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= bfct_pkg::CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off <= n_off;
    end

    // A stage loads when it is empty or its content moves on this cycle
    assign en5 = !r_v5 || i_m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            org[c] = bfct_pkg::t_coord'(i_s_axis_tdata[c*bfct_pkg::COORD_W +: bfct_pkg::COORD_W]);
        end
    end

    // Stage 1: twelve 32x32 products plus the translation column scaled by one
    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int r = 0; r < bfct_pkg::NUM_ROWS; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= coef[r][c] * org[c];
                end
                r_trans[r] <= bfct_pkg::t_acc'(coef[r][3]) <<< bfct_pkg::FRAC_BITS;
            end
        end
    end

    // Stage 2: pair sums
    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int r = 0; r < bfct_pkg::NUM_ROWS; r++) begin
                r_pa[r] <= bfct_pkg::t_acc'(r_prod[r][0]) + bfct_pkg::t_acc'(r_prod[r][1]);
                r_pb[r] <= bfct_pkg::t_acc'(r_prod[r][2]) + r_trans[r];
            end
        end
    end

    // Stage 3: clip components of the minimum corner
    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int r = 0; r < bfct_pkg::NUM_ROWS; r++) begin
                r_base[r] <= r_pa[r] + r_pb[r];
            end
        end
    end

    // Stage 4: the transform is linear, so each corner is the base plus its offset
    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int k = 0; k < bfct_pkg::NUM_CORNERS; k++) begin
                for (int r = 0; r < bfct_pkg::NUM_ROWS; r++) begin
                    r_clip[k][r] <= r_base[r] + r_off[r][k];
                end
            end
        end
    end

    // Strict inside test per corner
    always_comb begin
        bfct_pkg::t_acc w;
        bfct_pkg::t_acc nw;
        for (int k = 0; k < bfct_pkg::NUM_CORNERS; k++) begin
            w  = r_clip[k][bfct_pkg::ROW_W];
            nw = -w;
            w_pos[k]  = w > bfct_pkg::t_acc'(0);
            corner_in[k] = (nw < r_clip[k][bfct_pkg::ROW_X]) && (r_clip[k][bfct_pkg::ROW_X] < w)
                        && (nw < r_clip[k][bfct_pkg::ROW_Y]) && (r_clip[k][bfct_pkg::ROW_Y] < w)
                        && (r_clip[k][bfct_pkg::ROW_Z] > bfct_pkg::t_acc'(0))
                        && (r_clip[k][bfct_pkg::ROW_Z] < w);
        end
    end

    // Stage 5: any corner inside marks the chunk visible
    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_vis <= |corner_in;
        end
    end

    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {{(bfct_pkg::OUT_W-1){1'b0}}, r_vis};

    // The pipeline never refuses input while the output side takes every transfer
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output drains");

    // A full stage whose successor loads hands its item on
    a_stage4_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en5) |=> r_v5)
        else $error("item lost between corner and verdict stages");

    // No corner with non-positive w can be inside
    a_no_w_no_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en5 && (w_pos == '0)) |=> (o_m_axis_tdata[0] == 1'b0))
        else $error("visible reported with no corner in front of the eye");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the chunk clip-space corner test unit.
`timescale 1ns / 1ps

module tb;
    import bfct_pkg::*;

    // Run limits: the whole run and the settle time after the last verdict.
    localparam int LIMIT_CYCLES  = 400_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 66;
    localparam int ONE_Q         = 65536;

    typedef t_cfg clip_mat_t [NUM_CFG];

    // Matrices used by the directed part.
    typedef enum logic [2:0] {
        MAT_IDENTITY,
        MAT_ZERO,
        MAT_ONES,
        MAT_PEAK,
        MAT_VIEW
    } mat_sel_e;

    typedef struct packed {
        mat_sel_e    mat;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        bit          typed;
        bit          vis;
    } origin_row_t;

    typedef struct {
        t_coord ox;
        t_coord oy;
        t_coord oz;
        bit     vis;
    } verdict_t;

    // Directed rows. A typed verdict is used where the answer is plain from the
    // matrix; every other row is checked against the predictor.
    localparam int N_DIRECTED = 22;
    localparam origin_row_t DIRECTED [N_DIRECTED] = '{
        // identity matrix straight out of reset
        '{MAT_IDENTITY, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0},
        '{MAT_IDENTITY, -32'sd32768, -32'sd32768, 32'sd16384, 1'b1, 1'b1},
        // chunk straddles the volume but no corner is inside; then origins at the extremes
        '{MAT_IDENTITY, -32'sd1048576, -32'sd1048576, -32'sd1048576, 1'b1, 1'b0},
        '{MAT_IDENTITY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0},
        '{MAT_IDENTITY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0},
        // only the far corner lands inside
        '{MAT_IDENTITY, -32'sd2097152, -32'sd2097152, -32'sd2064384, 1'b1, 1'b1},
        // x exactly on -w: strict test fails
        '{MAT_IDENTITY, -32'sd65536, -32'sd32768, 32'sd32768, 1'b1, 1'b0},
        '{MAT_IDENTITY, -32'sd65535, -32'sd32768, 32'sd32768, 1'b1, 1'b1},
        // z exactly on the near plane
        '{MAT_IDENTITY, -32'sd32768, -32'sd32768, 32'sd0, 1'b1, 1'b0},
        // degenerate all-zero matrix never passes
        '{MAT_ZERO, -32'sd32768, -32'sd32768, 32'sd16384, 1'b1, 1'b0},
        '{MAT_ZERO, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0},
        '{MAT_ZERO, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 1'b1, 1'b0},
        // every coefficient at all ones
        '{MAT_ONES, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
        '{MAT_ONES, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0},
        '{MAT_ONES, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
        // coefficients at the signed extremes
        '{MAT_PEAK, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
        '{MAT_PEAK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0},
        '{MAT_PEAK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
        // scaled view matrix
        '{MAT_VIEW, -32'sd1048576, -32'sd1048576, 32'sd262144, 1'b0, 1'b0},
        '{MAT_VIEW, -32'sd2621440, 32'sd655360, 32'sd1310720, 1'b0, 1'b0},
        '{MAT_VIEW, 32'h7FFF_FFFF, 32'sd0, 32'h8000_0000, 1'b0, 1'b0},
        '{MAT_VIEW, -32'sd3145728, -32'sd3145728, -32'sd2031616, 1'b0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic              s_valid   = 1'b0;
    logic [IN_W-1:0]   s_data    = '0;
    logic              s_ready;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [OUT_W-1:0]  m_data;
    logic              cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    t_cfg              cfg_wdata = '0;

    // Typed verdict travelling alongside the transfer on the input side.
    bit                s_typed     = 1'b0;
    bit                s_typed_vis = 1'b0;

    // Shadow of the clip matrix as the unit holds it.
    clip_mat_t         clip_mat = CFG_RESET;
    verdict_t          pending_verdicts [$];
    verdict_t          head;
    verdict_t          fresh;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count    = 0;
    bit                quiet_phase    = 1'b0;

    box_frustum_corner_test_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Predict the verdict: transform all eight corners exactly at 128 bits and
    // look for one strictly inside the clip volume.
    function automatic bit chunk_visible(input clip_mat_t m, input t_coord ox,
                                         input t_coord oy, input t_coord oz);
        logic signed [127:0] coef [4][4];
        logic signed [127:0] pt [4];
        logic signed [127:0] clip [4];
        logic signed [127:0] neg_w;
        bit hit;
        hit = 1'b0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (c % 2 == 1)
                    coef[r][c] = $signed(m[r * 2 + c / 2][63:32]);
                else
                    coef[r][c] = $signed(m[r * 2 + c / 2][31:0]);
            end
        end
        for (int k = 0; k < NUM_CORNERS; k++) begin
            pt[0] = ox;
            pt[1] = oy;
            pt[2] = oz;
            pt[3] = ONE_Q;
            if (k[2]) pt[0] = pt[0] + EDGE_Q;
            if (k[1]) pt[1] = pt[1] + EDGE_Q;
            if (k[0]) pt[2] = pt[2] + EDGE_Q;
            for (int r = 0; r < 4; r++) begin
                clip[r] = '0;
                for (int c = 0; c < 4; c++)
                    clip[r] = clip[r] + coef[r][c] * pt[c];
            end
            neg_w = -clip[ROW_W];
            if (neg_w < clip[ROW_X] && clip[ROW_X] < clip[ROW_W] &&
                neg_w < clip[ROW_Y] && clip[ROW_Y] < clip[ROW_W] &&
                0 < clip[ROW_Z] && clip[ROW_Z] < clip[ROW_W])
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Pack a 4x4 coefficient grid into the eight register words.
    function automatic clip_mat_t pack_rows(input int cf [4][4]);
        clip_mat_t m;
        for (int r = 0; r < 4; r++) begin
            m[r * 2]     = {cf[r][1], cf[r][0]};
            m[r * 2 + 1] = {cf[r][3], cf[r][2]};
        end
        return m;
    endfunction

    function automatic clip_mat_t directed_matrix(input mat_sel_e sel);
        clip_mat_t m;
        int cf [4][4];
        case (sel)
            MAT_ZERO: begin
                foreach (m[i]) m[i] = '0;
            end
            MAT_ONES: begin
                foreach (m[i]) m[i] = '1;
            end
            MAT_PEAK: begin
                foreach (m[i]) m[i] = (i % 2 == 0) ? 64'h8000_0000_7FFF_FFFF
                                                   : 64'h7FFF_FFFF_8000_0000;
            end
            MAT_VIEW: begin
                foreach (cf[r, c]) cf[r][c] = 0;
                cf[ROW_X][0] = 2048;
                cf[ROW_Y][1] = 2048;
                cf[ROW_Z][2] = 2048;
                cf[ROW_W][3] = ONE_Q;
                m = pack_rows(cf);
            end
            default: m = CFG_RESET;
        endcase
        return m;
    endfunction

    // Random view-style matrix: scaled axes with some shear, a shift and an
    // optional perspective term in w. win is the world window in whole units.
    function automatic clip_mat_t random_view(output int win);
        int cf [4][4];
        int sh;
        int s;
        sh  = $urandom_range(4, 8);
        s   = ONE_Q >> sh;
        win = 1 << sh;
        foreach (cf[r, c]) cf[r][c] = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++)
                cf[r][c] = (r == c) ? s : int'($urandom_range(0, s / 4)) - s / 8;
        end
        cf[ROW_X][3] = int'($urandom_range(0, ONE_Q)) - ONE_Q / 2;
        cf[ROW_Y][3] = int'($urandom_range(0, ONE_Q)) - ONE_Q / 2;
        cf[ROW_Z][3] = int'($urandom_range(0, 49152)) - 16384;
        cf[ROW_W][3] = ONE_Q;
        if ($urandom_range(0, 1) == 1)
            cf[ROW_W][2] = s / 2;
        return pack_rows(cf);
    endfunction

    // Mostly short gaps, now and then a long one; none in a quiet phase.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_coord near_coord(input int win);
        return int'($urandom_range(0, 4 * win * ONE_Q)) - 2 * win * ONE_Q;
    endfunction

    // Offer one origin and hold it until the unit takes the transfer.
    // Called and returns at a falling edge.
    task automatic push_origin(input t_coord ox, input t_coord oy, input t_coord oz,
                               input bit typed, input bit vis);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid     <= 1'b1;
        s_data      <= {oz, oy, ox};
        s_typed     <= typed;
        s_typed_vis <= vis;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every outstanding verdict, then let the pipe empty.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all eight matrix registers back to back; only while the unit is idle.
    task automatic load_matrix(input clip_mat_t m);
        for (int i = 0; i < NUM_CFG; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_IDX_W'(i);
            cfg_wdata <= m[i];
            clip_mat[i] = m[i];
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Record each accepted origin and check each verdict against the oldest record.
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready) begin
            fresh.ox  = t_coord'(s_data[COORD_W-1:0]);
            fresh.oy  = t_coord'(s_data[2*COORD_W-1:COORD_W]);
            fresh.oz  = t_coord'(s_data[3*COORD_W-1:2*COORD_W]);
            fresh.vis = s_typed ? s_typed_vis
                                : chunk_visible(clip_mat, fresh.ox, fresh.oy, fresh.oz);
            pending_verdicts.push_back(fresh);
        end
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected verdict: expected none actual %0d",
                         $time, m_data[0]);
            end else begin
                head = pending_verdicts.pop_front();
                if (m_data[0] !== head.vis) begin
                    mismatch_count++;
                    $display("%0t: visible for origin (%h %h %h): expected %0d actual %0d",
                             $time, head.ox, head.oy, head.oz, head.vis, m_data[0]);
                end
            end
        end
    end

    // Receiver: ready in random bursts with random stalls between, always ready in a quiet phase.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (quiet_phase) begin
                m_ready <= 1'b1;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run if it overstays the cycle budget.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        mat_sel_e    cur_mat;
        origin_row_t row;
        clip_mat_t   m;
        int          win;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: switch matrices only with the pipe empty.
        cur_mat = MAT_IDENTITY;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (row.mat != cur_mat) begin
                settle_pipeline();
                load_matrix(directed_matrix(row.mat));
                cur_mat = row.mat;
            end
            push_origin(row.ox, row.oy, row.oz, row.typed, row.vis);
        end

        // Random part: one matrix per phase, origins mostly near its window.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle_pipeline();
            if (ph == 3) begin
                foreach (m[i]) m[i] = {$urandom, $urandom};
                win = 64;
            end else begin
                m = random_view(win);
            end
            quiet_phase = (ph == 5);
            load_matrix(m);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0)
                    push_origin($urandom, $urandom, $urandom, 1'b0, 1'b0);
                else
                    push_origin(near_coord(win), near_coord(win), near_coord(win),
                                1'b0, 1'b0);
            end
        end
        quiet_phase = 1'b0;

        settle_pipeline();
        mismatch_count += pending_verdicts.size();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
